FILE: rtl/core/vls_pkg.sv
package vls_pkg;

  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_COMPUTE = 2'd1;
  localparam logic [1:0] OP_OOR     = 2'd2;

  localparam logic [2:0] KIND_SMOKE    = 3'd0;
  localparam logic [2:0] KIND_VEL_X    = 3'd1;
  localparam logic [2:0] KIND_VEL_Y    = 3'd2;
  localparam logic [2:0] KIND_VEL_Z    = 3'd3;
  localparam logic [2:0] KIND_PRESSURE = 3'd4;

  localparam logic [2:0] CFG_SIZE_X      = 3'd0;
  localparam logic [2:0] CFG_SIZE_Y      = 3'd1;
  localparam logic [2:0] CFG_SIZE_Z      = 3'd2;
  localparam logic [2:0] CFG_FIELD_KIND  = 3'd3;
  localparam logic [2:0] CFG_POROUS_MODE = 3'd4;
  localparam logic [2:0] CFG_DIFF_FACTOR = 3'd5;
  localparam logic [2:0] CFG_INV_AREA    = 3'd6;

  localparam logic [16:0] ONE_POR = 17'd65536;
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic               func;
    logic [4:0]         pos_x;
    logic [4:0]         pos_y;
    logic [4:0]         pos_z;
    logic signed [31:0] cell_value;
    logic               is_solid;
    logic               smoke_fixed;
    logic               velocity_fixed;
    logic               pressure_fixed;
    logic [16:0]        porosity;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               skipped;
    logic [2:0]         neighbor_count;
    logic               out_of_range;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [4:0]  x;
    logic [4:0]  y;
    logic [4:0]  z;
    logic [31:0] value;
    logic [3:0]  flags;
    logic [16:0] por;
    logic [5:0]  nb_en;
    logic [2:0]  count;
  } job_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic        porous;
    logic [31:0] diff_factor;
    logic [31:0] inv_area;
  } cfg_t;

endpackage

FILE: rtl/core/voxel_laplacian_stencil.sv
// Load: queued like any job and written to the voxel memory when the back end pops it; no result.
// A compute reads the centre and its six neighbours serially from the voxel memory, then runs
// a two-part rounding multiply; a skipped compute stops before the multiply and an out-of-range
// compute bypasses both. The back end takes a new job only when idle; loads then sustain one per cycle.
// Reset (synchronous, rst_n low) sets config and control registers to defaults and empties the
// job queue; the voxel memory is undefined until loaded. Results cannot stall.
module voxel_laplacian_stencil #(
  parameter int MAX_DIM     = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  vls_pkg::in_item_t  in_item,
  output logic               out_valid,
  output vls_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import vls_pkg::*;

  logic push, pop, empty, full;
  job_t push_job, head_job;
  cfg_t cfg;

  assign busy      = full;
  assign cfg_ready = 1'b1;

  vls_front #(.MAX_DIM(MAX_DIM), .VALUE_WIDTH(VALUE_WIDTH)) u_front (
    .clk, .rst_n, .start, .busy, .in_item,
    .cfg_valid, .cfg_index, .cfg_data,
    .push, .job(push_job), .cfg
  );

  vls_queue u_queue (
    .clk, .rst_n, .push, .push_data(push_job),
    .pop, .pop_data(head_job), .empty, .full
  );

  vls_back #(.MAX_DIM(MAX_DIM), .VALUE_WIDTH(VALUE_WIDTH)) u_back (
    .clk, .rst_n, .job(head_job), .job_valid(!empty), .job_pop(pop),
    .cfg, .out_valid, .out_item
  );

endmodule

FILE: rtl/core/vls_front.sv
module vls_front #(
  parameter int MAX_DIM     = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  vls_pkg::in_item_t in_item,
  input  logic              cfg_valid,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  output logic              push,
  output vls_pkg::job_t     job,
  output vls_pkg::cfg_t     cfg
);
  import vls_pkg::*;

  localparam int SW = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
  localparam int NW = ($clog2(MAX_DIM + 1) > 6) ? $clog2(MAX_DIM + 1) : 6;
  localparam logic signed [31:0] VHI = 32'((64'sd1 <<< (SW - 1)) - 64'sd1);
  localparam logic signed [31:0] VLO = -VHI - 32'sd1;

  logic [5:0]  size_x_r, size_y_r, size_z_r;
  logic [2:0]  kind_r;
  logic        porous_r;
  logic [31:0] dif_r, inv_r;

  logic [NW-1:0] nx, ny, nz, px, py, pz;
  logic          oor, drop;
  logic [5:0]    en;

  function automatic logic [NW-1:0] clamp_ext(input logic [5:0] s);
    logic [NW-1:0] e;
    e = NW'(s);
    if (s == 6'd0) return NW'(1);
    if (e > NW'(MAX_DIM)) return NW'(MAX_DIM);
    return e;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r <= 6'd32;
      size_y_r <= 6'd32;
      size_z_r <= 6'd32;
      kind_r   <= KIND_SMOKE;
      porous_r <= 1'b0;
      dif_r    <= 32'd0;
      inv_r    <= 32'd65536;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SIZE_X:      size_x_r <= cfg_data[5:0];
        CFG_SIZE_Y:      size_y_r <= cfg_data[5:0];
        CFG_SIZE_Z:      size_z_r <= cfg_data[5:0];
        CFG_FIELD_KIND:  kind_r   <= cfg_data[2:0];
        CFG_POROUS_MODE: porous_r <= cfg_data[0];
        CFG_DIFF_FACTOR: dif_r    <= cfg_data;
        CFG_INV_AREA:    inv_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg = '{kind: kind_r, porous: porous_r, diff_factor: dif_r, inv_area: inv_r};

  always_comb begin
    nx = clamp_ext(size_x_r);
    ny = clamp_ext(size_y_r);
    nz = clamp_ext(size_z_r);
    px = NW'(in_item.pos_x);
    py = NW'(in_item.pos_y);
    pz = NW'(in_item.pos_z);
    oor  = (px >= nx) || (py >= ny) || (pz >= nz);
    drop = (px >= NW'(MAX_DIM)) || (py >= NW'(MAX_DIM)) || (pz >= NW'(MAX_DIM));
    en = {(pz + NW'(1)) < nz, pz != '0, (py + NW'(1)) < ny, py != '0,
          (px + NW'(1)) < nx, px != '0};

    job.x     = in_item.pos_x;
    job.y     = in_item.pos_y;
    job.z     = in_item.pos_z;
    job.flags = {in_item.pressure_fixed, in_item.velocity_fixed,
                 in_item.smoke_fixed, in_item.is_solid};
    job.por   = (in_item.porosity > ONE_POR) ? ONE_POR : in_item.porosity;
    if (in_item.cell_value > VHI) job.value = VHI;
    else if (in_item.cell_value < VLO) job.value = VLO;
    else job.value = in_item.cell_value;
    job.nb_en = en;
    job.count = 3'($countones(en));
    if (!in_item.func) job.op = OP_LOAD;
    else if (oor) job.op = OP_OOR;
    else job.op = OP_COMPUTE;

    push = start && !busy && !(!in_item.func && drop);
  end

endmodule

FILE: rtl/core/vls_queue.sv
module vls_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  vls_pkg::job_t push_data,
  input  logic          pop,
  output vls_pkg::job_t pop_data,
  output logic          empty,
  output logic          full
);
  import vls_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  job_t          slot_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] fill_r;

  assign empty    = fill_r == '0;
  assign full     = fill_r == CW'(QUEUE_DEPTH);
  assign pop_data = slot_r[rd_ptr_r];

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) wr_ptr_r <= bump(wr_ptr_r);
      if (pop) rd_ptr_r <= bump(rd_ptr_r);
      if (push && !pop) fill_r <= fill_r + CW'(1);
      else if (pop && !push) fill_r <= fill_r - CW'(1);
    end
  end

endmodule

FILE: rtl/core/vls_back.sv
module vls_back #(
  parameter int MAX_DIM     = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  vls_pkg::job_t      job,
  input  logic               job_valid,
  output logic               job_pop,
  input  vls_pkg::cfg_t      cfg,
  output logic               out_valid,
  output vls_pkg::out_item_t out_item
);
  import vls_pkg::*;

  localparam int SW    = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
  localparam int DEPTH = MAX_DIM * MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int MW    = SW + 21;
  localparam int TW    = SW + 21;
  localparam int DW    = SW + 25;
  localparam int PW    = DW + 1;
  localparam int RW    = PW + 2;
  localparam logic signed [RW-1:0] RHI = RW'((64'sd1 <<< (SW - 1)) - 64'sd1);
  localparam logic signed [RW-1:0] RLO = -RHI - RW'(1);

  localparam logic [2:0] TAG_CENTRE = 3'd0;
  localparam logic [2:0] TAG_LAST   = 3'd6;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RUN   = 4'd1;
  localparam logic [3:0] S_DRAIN = 4'd2;
  localparam logic [3:0] S_DIFF  = 4'd3;
  localparam logic [3:0] S_ABS   = 4'd4;
  localparam logic [3:0] S_MLO   = 4'd5;
  localparam logic [3:0] S_MHI   = 4'd6;
  localparam logic [3:0] S_SUM   = 4'd7;
  localparam logic [3:0] S_SAT   = 4'd8;

  logic [MW-1:0] mem [DEPTH];

  logic [3:0]  state_r, state_nxt;
  job_t        job_r;
  logic [2:0]  iss_r, q_tag_r;
  logic        q_vld_r, t_vld_r, t_last_r, acc_done_r, skip_r, neg_r, out_vld_r;
  logic [MW-1:0] mem_q_r;
  logic signed [SW-1:0] v_r;
  logic signed [TW-1:0] term_r;
  logic signed [DW-1:0] acc_r, diff_r;
  logic [DW-1:0] mag_r, phi_r;
  logic [63:0]   plo_r;
  logic signed [RW-1:0] res_r;
  out_item_t out_r;

  logic [5:0]  cx, cy, cz, ax, ay, az;
  logic [AW-1:0] rd_addr, wr_addr;
  logic signed [SW-1:0] nv;
  logic [3:0]  nflags;
  logic [16:0] npor, peff;
  logic signed [SW:0]    v_ext, bc;
  logic signed [SW+1:0]  dnb;
  logic signed [SW+19:0] prod;
  logic signed [TW-1:0]  term;
  logic        t_en, cen_skip, pop_load, pop_oor, pop_comp;
  logic signed [SW+3:0]  cv;
  logic [31:0] coef;
  logic [64:0] rnd;
  logic [PW-1:0] p;
  logic signed [PW:0] sp;
  logic signed [SW-1:0] rsat;

  function automatic logic [AW-1:0] addr_of(input logic [5:0] x, input logic [5:0] y,
                                            input logic [5:0] z);
    return (AW'(x) * AW'(MAX_DIM) + AW'(y)) * AW'(MAX_DIM) + AW'(z);
  endfunction

  assign job_pop  = (state_r == S_IDLE) && job_valid;
  assign pop_load = job_pop && (job.op == OP_LOAD);
  assign pop_oor  = job_pop && (job.op == OP_OOR);
  assign pop_comp = job_pop && (job.op == OP_COMPUTE);

  always_comb begin
    cx = {1'b0, job_r.x};
    cy = {1'b0, job_r.y};
    cz = {1'b0, job_r.z};
    ax = cx;
    ay = cy;
    az = cz;
    case (iss_r)
      3'd1: if (job_r.nb_en[0]) ax = cx - 6'd1;
      3'd2: if (job_r.nb_en[1]) ax = cx + 6'd1;
      3'd3: if (job_r.nb_en[2]) ay = cy - 6'd1;
      3'd4: if (job_r.nb_en[3]) ay = cy + 6'd1;
      3'd5: if (job_r.nb_en[4]) az = cz - 6'd1;
      3'd6: if (job_r.nb_en[5]) az = cz + 6'd1;
      default: ;
    endcase
    rd_addr = addr_of(ax, ay, az);
    wr_addr = addr_of({1'b0, job.x}, {1'b0, job.y}, {1'b0, job.z});
  end

  always_ff @(posedge clk) begin
    if (pop_load) mem[wr_addr] <= {job.por, job.flags, job.value[SW-1:0]};
    if (state_r == S_RUN) mem_q_r <= mem[rd_addr];
  end

  always_comb begin
    nv     = mem_q_r[SW-1:0];
    nflags = mem_q_r[SW+3:SW];
    npor   = mem_q_r[MW-1:SW+4];
    v_ext  = (SW+1)'(v_r);
    bc     = '0;
    if (cfg.kind == KIND_SMOKE || cfg.kind == KIND_PRESSURE) bc = v_ext;
    else if (cfg.kind == KIND_VEL_X && (q_tag_r == 3'd1 || q_tag_r == 3'd2)) bc = -v_ext;
    else if (cfg.kind == KIND_VEL_Y && (q_tag_r == 3'd3 || q_tag_r == 3'd4)) bc = -v_ext;
    else if (cfg.kind == KIND_VEL_Z && (q_tag_r == 3'd5 || q_tag_r == 3'd6)) bc = -v_ext;
    peff = cfg.porous ? npor : (nflags[0] ? 17'd0 : ONE_POR);
    dnb  = (SW+2)'(nv) - (SW+2)'(bc);
    prod = $signed({1'b0, peff}) * dnb;
    term = (TW'(bc) <<< 16) + TW'(prod);
    t_en = (q_tag_r != TAG_CENTRE) && job_r.nb_en[q_tag_r - 3'd1];
    cen_skip = nflags[0] ||
               (cfg.kind == KIND_SMOKE && nflags[1]) ||
               (cfg.kind >= KIND_VEL_X && cfg.kind <= KIND_VEL_Z && nflags[2]) ||
               (cfg.kind == KIND_PRESSURE && nflags[3]);
  end

  always_comb begin
    cv   = $signed({1'b0, job_r.count}) * v_r;
    coef = (cfg.kind == KIND_PRESSURE) ? cfg.inv_area : cfg.diff_factor;
    rnd  = 65'(plo_r) + 65'h0_8000_0000;
    p    = PW'(phi_r) + PW'(rnd[64:32]);
    sp   = neg_r ? -$signed({1'b0, p}) : $signed({1'b0, p});
    if (res_r > RHI) rsat = SW'(RHI);
    else if (res_r < RLO) rsat = SW'(RLO);
    else rsat = SW'(res_r);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (pop_comp) state_nxt = S_RUN;
      S_RUN:   if (iss_r == TAG_LAST) state_nxt = S_DRAIN;
      S_DRAIN: if (acc_done_r) state_nxt = S_DIFF;
      S_DIFF:  state_nxt = skip_r ? S_IDLE : S_ABS;
      S_ABS:   state_nxt = S_MLO;
      S_MLO:   state_nxt = S_MHI;
      S_MHI:   state_nxt = S_SUM;
      S_SUM:   state_nxt = S_SAT;
      S_SAT:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      q_vld_r    <= 1'b0;
      t_vld_r    <= 1'b0;
      acc_done_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      q_vld_r   <= state_r == S_RUN;
      t_vld_r   <= q_vld_r && (q_tag_r != TAG_CENTRE);
      out_vld_r <= pop_oor || (state_r == S_DIFF && skip_r) || state_r == S_SAT;
      if (pop_comp) acc_done_r <= 1'b0;
      else if (t_vld_r && t_last_r) acc_done_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_comp) job_r <= job;
    if (pop_comp) iss_r <= TAG_CENTRE;
    else if (state_r == S_RUN) iss_r <= iss_r + 3'd1;
    q_tag_r  <= iss_r;
    t_last_r <= q_tag_r == TAG_LAST;
    if (q_vld_r && q_tag_r == TAG_CENTRE) begin
      v_r    <= nv;
      skip_r <= cen_skip;
    end
    term_r <= t_en ? term : '0;
    if (pop_comp) acc_r <= '0;
    else if (t_vld_r) acc_r <= acc_r + DW'(term_r);
    if (state_r == S_DIFF) diff_r <= (DW'(cv) <<< 16) - acc_r;
    if (state_r == S_ABS) begin
      neg_r <= diff_r[DW-1];
      mag_r <= diff_r[DW-1] ? DW'(-diff_r) : DW'(diff_r);
    end
    if (state_r == S_MLO) plo_r <= 64'(mag_r[31:0]) * 64'(coef);
    if (state_r == S_MHI) phi_r <= DW'(mag_r[DW-1:32]) * DW'(coef);
    if (state_r == S_SUM) begin
      if (cfg.kind == KIND_PRESSURE) res_r <= RW'(sp);
      else res_r <= RW'(sp) + RW'(v_r);
    end
    if (pop_oor) out_r <= '{result_value: '0, skipped: 1'b0, neighbor_count: '0,
                            out_of_range: 1'b1};
    else if (state_r == S_DIFF && skip_r)
      out_r <= '{result_value: '0, skipped: 1'b1, neighbor_count: '0, out_of_range: 1'b0};
    else if (state_r == S_SAT)
      out_r <= '{result_value: 32'(rsat), skipped: 1'b0, neighbor_count: job_r.count,
                 out_of_range: 1'b0};
  end

  assign out_valid = out_vld_r;
  assign out_item  = out_r;

endmodule

FILE: verif/voxel_laplacian_stencil_checker.sv
`timescale 1ns / 1ps

module voxel_laplacian_stencil_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  vls_pkg::in_item_t  in_item,
  input  logic               out_valid,
  input  vls_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output int                 errors,
  output int                 pending
);
  import vls_pkg::*;

  localparam int DIM   = 32;
  localparam int DEPTH = DIM * DIM * DIM;

  logic signed [31:0] voxel_value [DEPTH];
  logic [3:0]         voxel_flags [DEPTH];
  logic [16:0]        voxel_por   [DEPTH];

  logic [5:0]  dim_x, dim_y, dim_z;
  logic [2:0]  kind;
  logic        porous;
  logic [31:0] diff_factor;
  logic [31:0] inv_area;

  out_item_t result_q[$];

  function automatic int clamp_dim(logic [5:0] s);
    if (s < 1) return 1;
    if (s > DIM) return DIM;
    return int'(s);
  endfunction

  function automatic int voxel_addr(int x, int y, int z);
    return (x * DIM + y) * DIM + z;
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint round_product(longint a, longint unsigned b);
    longint unsigned m, hi, lo, p;
    m  = (a < 0) ? longint'(-a) : a;
    hi = m >> 32;
    lo = m & 64'hFFFF_FFFF;
    p  = hi * b + ((lo * b + 64'h8000_0000) >> 32);
    return (a < 0) ? -longint'(p) : longint'(p);
  endfunction

  function automatic longint neighbour_term(int a, longint bc);
    longint nv, p;
    nv = voxel_value[a];
    if (porous) begin
      p = voxel_por[a];
      return (65536 - p) * bc + p * nv;
    end
    return (voxel_flags[a][0] ? bc : nv) * 65536;
  endfunction

  function automatic out_item_t stencil_result(in_item_t it);
    out_item_t r;
    int x, y, z, nx, ny, nz, a, count;
    logic [3:0] fl;
    logic skip;
    longint v, bcx, bcy, bcz, sum, diff, res;
    r = '0;
    x = it.pos_x;
    y = it.pos_y;
    z = it.pos_z;
    nx = clamp_dim(dim_x);
    ny = clamp_dim(dim_y);
    nz = clamp_dim(dim_z);
    if (x >= nx || y >= ny || z >= nz) begin
      r.out_of_range = 1'b1;
      return r;
    end
    a  = voxel_addr(x, y, z);
    fl = voxel_flags[a];
    skip = fl[0] || (kind == KIND_SMOKE && fl[1]) ||
           (kind >= KIND_VEL_X && kind <= KIND_VEL_Z && fl[2]) ||
           (kind == KIND_PRESSURE && fl[3]);
    if (skip) begin
      r.skipped = 1'b1;
      return r;
    end
    v = voxel_value[a];
    if (kind == KIND_SMOKE || kind == KIND_PRESSURE) begin
      bcx = v;
      bcy = v;
      bcz = v;
    end else begin
      bcx = (kind == KIND_VEL_X) ? -v : 0;
      bcy = (kind == KIND_VEL_Y) ? -v : 0;
      bcz = (kind == KIND_VEL_Z) ? -v : 0;
    end
    sum = 0;
    count = 0;
    if (x > 0)      begin sum += neighbour_term(voxel_addr(x - 1, y, z), bcx); count++; end
    if (x + 1 < nx) begin sum += neighbour_term(voxel_addr(x + 1, y, z), bcx); count++; end
    if (y > 0)      begin sum += neighbour_term(voxel_addr(x, y - 1, z), bcy); count++; end
    if (y + 1 < ny) begin sum += neighbour_term(voxel_addr(x, y + 1, z), bcy); count++; end
    if (z > 0)      begin sum += neighbour_term(voxel_addr(x, y, z - 1), bcz); count++; end
    if (z + 1 < nz) begin sum += neighbour_term(voxel_addr(x, y, z + 1), bcz); count++; end
    diff = longint'(count) * v * 65536 - sum;
    if (kind == KIND_PRESSURE) res = round_product(diff, inv_area);
    else res = v + round_product(diff, diff_factor);
    res = sat32(res);
    r.result_value   = res[31:0];
    r.neighbor_count = count[2:0];
    return r;
  endfunction

  initial errors = 0;

  always @(posedge clk) begin
    out_item_t want;
    int a;
    if (!rst_n) begin
      dim_x <= 6'd32;
      dim_y <= 6'd32;
      dim_z <= 6'd32;
      kind <= KIND_SMOKE;
      porous <= 1'b0;
      diff_factor <= '0;
      inv_area <= 32'd65536;
      result_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SIZE_X:      dim_x <= cfg_data[5:0];
          CFG_SIZE_Y:      dim_y <= cfg_data[5:0];
          CFG_SIZE_Z:      dim_z <= cfg_data[5:0];
          CFG_FIELD_KIND:  kind <= cfg_data[2:0];
          CFG_POROUS_MODE: porous <= cfg_data[0];
          CFG_DIFF_FACTOR: diff_factor <= cfg_data;
          CFG_INV_AREA:    inv_area <= cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) begin
        if (in_item.func == OP_COMPUTE[0]) begin
          result_q = {result_q, stencil_result(in_item)};
        end else begin
          a = voxel_addr(in_item.pos_x, in_item.pos_y, in_item.pos_z);
          voxel_value[a] = in_item.cell_value;
          voxel_flags[a] = {in_item.pressure_fixed, in_item.velocity_fixed,
                            in_item.smoke_fixed, in_item.is_solid};
          voxel_por[a] = (in_item.porosity > ONE_POR) ? ONE_POR : in_item.porosity;
        end
      end
      if (out_valid) begin
        if (result_q.size() == 0) begin
          $display("%0t: result with none expected, actual %h", $time, out_item);
          errors++;
        end else begin
          want = result_q.pop_front();
          if (out_item.result_value !== want.result_value) begin
            $display("%0t: result_value expected %h actual %h", $time,
                     want.result_value, out_item.result_value);
            errors++;
          end
          if (out_item.skipped !== want.skipped) begin
            $display("%0t: skipped expected %b actual %b", $time,
                     want.skipped, out_item.skipped);
            errors++;
          end
          if (out_item.neighbor_count !== want.neighbor_count) begin
            $display("%0t: neighbor_count expected %0d actual %0d", $time,
                     want.neighbor_count, out_item.neighbor_count);
            errors++;
          end
          if (out_item.out_of_range !== want.out_of_range) begin
            $display("%0t: out_of_range expected %b actual %b", $time,
                     want.out_of_range, out_item.out_of_range);
            errors++;
          end
        end
      end
    end
    pending = result_q.size();
  end

endmodule

FILE: verif/voxel_laplacian_stencil_tb.sv
`timescale 1ns / 1ps

module voxel_laplacian_stencil_tb;
  import vls_pkg::*;

  localparam int CYCLE_LIMIT = 150000;
  localparam int NUM_SETTINGS = 9;
  localparam int ITEMS_PER_SETTING = 117;
  localparam int LOW_BOX = 6;
  localparam int HIGH_BASE = 28;
  localparam logic [2:0] CFG_NONE = 3'd7;
  localparam logic [2:0] KIND_SPARE_LO = 3'd5;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_item_t    in_item;
  logic        out_valid;
  out_item_t   out_item;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  int          errors;
  int          pending;
  int          cycles;
  logic        req_taken;
  logic        cfg_taken;
  int          ext_x, ext_y, ext_z;

  voxel_laplacian_stencil u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  voxel_laplacian_stencil_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    req_taken <= start && !busy;
    cfg_taken <= cfg_valid && cfg_ready;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic int clamp_dim(logic [5:0] s);
    if (s < 1) return 1;
    if (s > 32) return 32;
    return int'(s);
  endfunction

  task automatic send_request(in_item_t it, int idle_pct);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_item = it;
    start = 1'b1;
    @(negedge clk);
    while (!req_taken) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    start = 1'b0;
    cfg_index = idx;
    cfg_data = data;
    cfg_valid = 1'b1;
    @(negedge clk);
    while (!cfg_taken) @(negedge clk);
    cfg_valid = 1'b0;
    if (idx == CFG_SIZE_X) ext_x = clamp_dim(data[5:0]);
    if (idx == CFG_SIZE_Y) ext_y = clamp_dim(data[5:0]);
    if (idx == CFG_SIZE_Z) ext_z = clamp_dim(data[5:0]);
  endtask

  task automatic drain;
    start = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  function automatic in_item_t make_request(logic func, int x, int y, int z,
                                            logic [31:0] val, logic [3:0] fl,
                                            logic [16:0] por);
    in_item_t it;
    it.func = func;
    it.pos_x = x[4:0];
    it.pos_y = y[4:0];
    it.pos_z = z[4:0];
    it.cell_value = val;
    {it.pressure_fixed, it.velocity_fixed, it.smoke_fixed, it.is_solid} = fl;
    it.porosity = por;
    return it;
  endfunction

  task automatic load_box(int lo, int hi);
    for (int x = lo; x <= hi; x++)
      for (int y = lo; y <= hi; y++)
        for (int z = lo; z <= hi; z++)
          send_request(make_request(OP_LOAD[0], x, y, z, $signed(32'($urandom)) >>> 10,
                                    ($urandom_range(3) == 0) ? 4'b0001 : 4'b0000,
                                    17'($urandom_range(65536))), 0);
  endtask

  function automatic int low_limit(int ext);
    return (ext <= LOW_BOX) ? ext - 1 : LOW_BOX - 2;
  endfunction

  function automatic in_item_t random_request();
    int x, y, z;
    logic [3:0] fl;
    logic [16:0] por;
    logic [31:0] val;
    if ($urandom_range(99) < 85) begin
      x = $urandom_range(low_limit(ext_x));
      y = $urandom_range(low_limit(ext_y));
      z = $urandom_range(low_limit(ext_z));
    end else begin
      x = $urandom_range(31, HIGH_BASE + 1);
      y = $urandom_range(31, HIGH_BASE + 1);
      z = $urandom_range(31, HIGH_BASE + 1);
    end
    fl = 4'($urandom);
    if ($urandom_range(99) < 60) fl = 4'b0000;
    case ($urandom_range(4))
      0: por = 17'd0;
      1: por = ONE_POR;
      2: por = 17'($urandom);
      default: por = 17'($urandom_range(65536));
    endcase
    val = $urandom;
    if ($urandom_range(9) == 0) val = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    else if ($urandom_range(3) != 0) val = $signed(val) >>> $urandom_range(8, 14);
    return make_request(1'($urandom_range(1)), x, y, z, val, fl, por);
  endfunction

  initial begin
    logic [5:0]  set_sx   [NUM_SETTINGS] = '{32, 1, 0, 4, 3, 8, 6, 63, 2};
    logic [5:0]  set_sy   [NUM_SETTINGS] = '{32, 1, 63, 4, 5, 8, 2, 32, 3};
    logic [5:0]  set_sz   [NUM_SETTINGS] = '{32, 1, 2, 4, 2, 8, 7, 33, 4};
    logic [2:0]  set_kind [NUM_SETTINGS] = '{KIND_SMOKE, KIND_PRESSURE, KIND_VEL_X,
                                             KIND_VEL_Y, KIND_VEL_Z, KIND_SPARE_LO,
                                             KIND_SPARE_HI, KIND_PRESSURE, KIND_SMOKE};
    logic        set_por  [NUM_SETTINGS] = '{0, 0, 1, 0, 1, 0, 1, 1, 1};
    int idle_pct;
    logic [31:0] df, ica;

    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cycles = 0;
    ext_x = 32;
    ext_y = 32;
    ext_z = 32;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    load_box(0, LOW_BOX - 1);
    load_box(HIGH_BASE, 31);

    send_request(make_request(OP_LOAD[0], 0, 0, 0, 32'h7FFF_FFFF, 4'b0000, 17'h1FFFF), 0);
    send_request(make_request(OP_LOAD[0], 1, 0, 0, 32'h8000_0000, 4'b0001, 17'd0), 0);
    send_request(make_request(OP_LOAD[0], 0, 1, 0, 32'h8000_0000, 4'b0000, ONE_POR), 0);
    send_request(make_request(OP_LOAD[0], 31, 31, 31, 32'hFFFF_FFFF, 4'b1110, 17'd0), 0);
    send_request(make_request(OP_LOAD[0], 31, 31, 30, 32'h0001_0000, 4'b1100, 17'd3), 0);
    send_request(make_request(OP_LOAD[0], 0, 0, 1, 32'h7FFF_FFFF, 4'b0000, 17'd65537), 0);
    send_request(make_request(OP_COMPUTE[0], 0, 0, 0, '0, '0, '0), 0);
    send_request(make_request(OP_COMPUTE[0], 1, 0, 0, '0, '0, '0), 0);
    send_request(make_request(OP_COMPUTE[0], 31, 31, 31, '0, '0, '0), 0);
    send_request(make_request(OP_COMPUTE[0], 31, 31, 30, '0, '0, '0), 0);
    send_request(make_request(OP_COMPUTE[0], 3, 4, 2, 32'hFFFF_FFFF, 4'hF, 17'h1FFFF), 0);
    drain();
    write_reg(CFG_POROUS_MODE, 32'd1);
    write_reg(CFG_DIFF_FACTOR, 32'hFFFF_FFFF);
    write_reg(CFG_NONE, 32'hFFFF_FFFF);
    send_request(make_request(OP_COMPUTE[0], 0, 0, 0, '0, '0, '0), 0);
    send_request(make_request(OP_COMPUTE[0], 0, 1, 0, '0, '0, '0), 0);
    send_request(make_request(OP_COMPUTE[0], 31, 31, 30, '0, '0, '0), 0);
    drain();
    write_reg(CFG_FIELD_KIND, 32'(KIND_PRESSURE));
    write_reg(CFG_INV_AREA, 32'hFFFF_FFFF);
    send_request(make_request(OP_COMPUTE[0], 0, 0, 0, '0, '0, '0), 0);
    send_request(make_request(OP_COMPUTE[0], 31, 31, 30, '0, '0, '0), 0);

    for (int s = 0; s < NUM_SETTINGS; s++) begin
      drain();
      case (s)
        1: begin df = 32'd0; ica = 32'hFFFF_FFFF; end
        2: begin df = 32'hFFFF_FFFF; ica = 32'd0; end
        3: begin df = 32'h0000_8000; ica = 32'h0001_0000; end
        default: begin df = $urandom; ica = $urandom; end
      endcase
      if (s == 0) begin
        df = 32'd0;
        ica = 32'd65536;
      end else if (s >= 4 && $urandom_range(1)) begin
        df = df >> $urandom_range(12, 20);
        ica = ica >> $urandom_range(8, 16);
      end
      write_reg(CFG_SIZE_X, {26'($urandom_range(3)), set_sx[s]});
      write_reg(CFG_SIZE_Y, 32'(set_sy[s]));
      write_reg(CFG_SIZE_Z, 32'(set_sz[s]));
      write_reg(CFG_FIELD_KIND, 32'(set_kind[s]));
      write_reg(CFG_POROUS_MODE, 32'(set_por[s]));
      write_reg(CFG_DIFF_FACTOR, df);
      write_reg(CFG_INV_AREA, ica);
      for (int i = 0; i < ITEMS_PER_SETTING; i++) begin
        case ((s * ITEMS_PER_SETTING + i) / 40 % 3)
          0: idle_pct = 0;
          1: idle_pct = 57;
          default: idle_pct = 19;
        endcase
        send_request(random_request(), idle_pct);
      end
    end

    start = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/vls_pkg.sv
rtl/core/vls_front.sv
rtl/core/vls_queue.sv
rtl/core/vls_back.sv
rtl/core/voxel_laplacian_stencil.sv
verif/voxel_laplacian_stencil_checker.sv
verif/voxel_laplacian_stencil_tb.sv
